// ===== rtl/rms_inverse_dynamics_gain_core_assert.svh =====
// Assertion macros for the checker file rmsidg_checker.sv.
`ifndef RMS_INVERSE_DYNAMICS_GAIN_CORE_ASSERT_SVH
`define RMS_INVERSE_DYNAMICS_GAIN_CORE_ASSERT_SVH

// Checked only out of reset.
`define RIDG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at every edge, reset included.
`define RIDG_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== rtl/rmsidg_pkg.sv =====
`default_nettype none
package rmsidg_pkg;

  localparam int unsigned HISTORY_DEPTH = 32768;
  localparam int unsigned CHANNELS      = 2;
  localparam int unsigned SAMPLE_BITS   = 24;

  localparam int unsigned WINDOW_W   = 16;
  localparam int unsigned BLOCK_W    = 13;
  localparam int unsigned CFG_ADDR_W = 1;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned BPOS_W     = 12;
  localparam int unsigned LEVEL_W    = 24;

  localparam logic [CFG_ADDR_W-1:0] REG_WINDOW = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_BLOCK  = 1'd1;

  localparam logic [WINDOW_W-1:0] WINDOW_RESET = 16'd19200;
  localparam logic [BLOCK_W-1:0]  BLOCK_RESET  = 13'd256;
  localparam int unsigned         MAX_BLOCK    = 4096;
  localparam int unsigned         EPS_Q24      = 17;
  localparam int unsigned         GAIN_ONE     = 65536;
  localparam int unsigned         GAIN_W       = 38;

  localparam int unsigned DIV_W      = 64;
  localparam int unsigned DIVISOR_W  = 32;
  localparam int unsigned SQRT_W     = 64;
  localparam int unsigned QUEUE_DEPTH = 2;

  typedef struct packed {
    logic pass;
    logic channel;
  } item_ctl_t;

endpackage
`default_nettype wire

// ===== rtl/rms_inverse_dynamics_gain_core.sv =====
// Channel   Dir  Handshake                      Payload
// s_axis    in   s_axis_tvalid/s_axis_tready    tdata: sample_in; tuser: channel
// m_axis    out  m_axis_tvalid/m_axis_tready    tdata: sample_out; tuser: channel_out
// cfg       in   cfg_we_i (no wait)             cfg_addr_i index, cfg_wdata_i value
//
// One word at a time in the back end: each word goes through the shared 64-step divider
// (used twice) and the 32-step square root.
// A word that starts a block first makes min(window_samples, samples held) history reads,
// one history read per cycle, then the mean divide and square root.
// The input register and a two-word queue keep taking words, until full, while the
// back end works or the output register waits. Reset clears all levels and positions at once.
`default_nettype none
module rms_inverse_dynamics_gain_core #(
  parameter int unsigned HISTORY_DEPTH = rmsidg_pkg::HISTORY_DEPTH,
  parameter int unsigned CHANNELS      = rmsidg_pkg::CHANNELS,
  parameter int unsigned SAMPLE_BITS   = rmsidg_pkg::SAMPLE_BITS,
  localparam int unsigned TDW          = (SAMPLE_BITS + 7) / 8 * 8
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [rmsidg_pkg::CFG_ADDR_W-1:0]    cfg_addr_i,
  input  logic [rmsidg_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [TDW-1:0]                       s_axis_tdata,  // sample_in
  input  logic [0:0]                           s_axis_tuser,  // channel
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  output logic [TDW-1:0]                       m_axis_tdata,  // sample_out
  output logic [0:0]                           m_axis_tuser   // channel_out
);

  logic [rmsidg_pkg::WINDOW_W-1:0] window_q;
  logic [rmsidg_pkg::BLOCK_W-1:0]  block_q;

  logic                   push_valid, push_ready, pop_valid, pop_ready;
  logic [SAMPLE_BITS+1:0] push_data, pop_data;
  logic [SAMPLE_BITS-1:0] out_sample;
  logic                   out_channel;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= rmsidg_pkg::WINDOW_RESET;
      block_q  <= rmsidg_pkg::BLOCK_RESET;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        rmsidg_pkg::REG_WINDOW: window_q <= cfg_wdata_i;
        rmsidg_pkg::REG_BLOCK:  block_q  <= cfg_wdata_i[rmsidg_pkg::BLOCK_W-1:0];
        default: ;
      endcase
    end
  end

  rmsidg_front #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .CHANNELS    (CHANNELS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_sample_i  (s_axis_tdata[SAMPLE_BITS-1:0]),
    .in_channel_i (s_axis_tuser[0]),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  rmsidg_queue #(
    .WIDTH (SAMPLE_BITS + 2)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  rmsidg_back #(
    .SAMPLE_BITS   (SAMPLE_BITS),
    .HISTORY_DEPTH (HISTORY_DEPTH),
    .CHANNELS      (CHANNELS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .window_i      (window_q),
    .block_i       (block_q),
    .pop_valid_i   (pop_valid),
    .pop_ready_o   (pop_ready),
    .pop_data_i    (pop_data),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .out_sample_o  (out_sample),
    .out_channel_o (out_channel)
  );

  assign m_axis_tdata    = TDW'(out_sample);
  assign m_axis_tuser[0] = out_channel;

endmodule
`default_nettype wire

// ===== rtl/rmsidg_front.sv =====
`default_nettype none
module rmsidg_front #(
  parameter int unsigned SAMPLE_BITS = rmsidg_pkg::SAMPLE_BITS,
  parameter int unsigned CHANNELS    = rmsidg_pkg::CHANNELS
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [SAMPLE_BITS-1:0] in_sample_i,
  input  logic                   in_channel_i,
  output logic                   push_valid_o,
  input  logic                   push_ready_i,
  output logic [SAMPLE_BITS+1:0] push_data_o
);

  logic                   vld_q;
  logic [SAMPLE_BITS-1:0] sample_q;
  rmsidg_pkg::item_ctl_t  ctl_q;
  rmsidg_pkg::item_ctl_t  ctl_d;

  assign in_ready_o   = !vld_q || push_ready_i;
  assign push_valid_o = vld_q;
  assign push_data_o  = {ctl_q, sample_q};

  always_comb begin
    ctl_d.channel = in_channel_i;
    ctl_d.pass    = ({31'd0, in_channel_i} >= 32'(CHANNELS));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      vld_q <= 1'b1;
    end else if (push_ready_i) begin
      vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      sample_q <= in_sample_i;
      ctl_q    <= ctl_d;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/rmsidg_queue.sv =====
`default_nettype none
module rmsidg_queue #(
  parameter int unsigned WIDTH = rmsidg_pkg::SAMPLE_BITS + 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output logic [WIDTH-1:0] pop_data_o
);

  localparam int unsigned DEPTH = rmsidg_pkg::QUEUE_DEPTH;
  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q;
  logic             push, pop;

  assign push_ready_o = (count_q != CNT_W'(DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = slot_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        count_q <= count_q + 1'b1;
      end else if (pop && !push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/rmsidg_div.sv =====
`default_nettype none
module rmsidg_div (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic [rmsidg_pkg::DIV_W-1:0]        dividend_i,
  input  logic [rmsidg_pkg::DIVISOR_W-1:0]    divisor_i,
  output logic                                done_o,
  output logic [rmsidg_pkg::DIV_W-1:0]        quotient_o
);

  localparam int unsigned DW = rmsidg_pkg::DIV_W;
  localparam int unsigned VW = rmsidg_pkg::DIVISOR_W;
  localparam int unsigned CW = $clog2(DW);

  logic          busy_q, done_q;
  logic [CW-1:0] cnt_q;
  logic [DW-1:0] quo_q;
  logic [VW:0]   rem_q;
  logic [VW-1:0] dvs_q;
  logic [VW:0]   rem_sh, rem_nx;
  logic          ge;

  always_comb begin
    rem_sh = {rem_q[VW-1:0], quo_q[DW-1]};
    ge     = (rem_sh >= {1'b0, dvs_q});
    rem_nx = ge ? rem_sh - {1'b0, dvs_q} : rem_sh;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == CW'(DW - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[DW-2:0], ge};
      rem_q <= rem_nx;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/rmsidg_isqrt.sv =====
`default_nettype none
module rmsidg_isqrt (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic [rmsidg_pkg::SQRT_W-1:0]      radicand_i,
  output logic                               done_o,
  output logic [rmsidg_pkg::SQRT_W/2-1:0]    root_o
);

  localparam int unsigned RW    = rmsidg_pkg::SQRT_W;
  localparam int unsigned QW    = RW / 2;
  localparam int unsigned MW    = QW + 2;
  localparam int unsigned CW    = $clog2(QW);

  logic          busy_q, done_q;
  logic [CW-1:0] cnt_q;
  logic [RW-1:0] rad_q;
  logic [QW-1:0] root_q;
  logic [MW-1:0] rem_q;
  logic [MW+1:0] rem_sh, trial;
  logic          ge;

  always_comb begin
    rem_sh = {rem_q, rad_q[RW-1:RW-2]};
    trial  = (MW + 2)'({root_q, 2'b01});
    ge     = (rem_sh >= trial);
  end

  assign done_o = done_q;
  assign root_o = root_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == CW'(QW - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= radicand_i;
      root_q <= '0;
      rem_q  <= '0;
    end else if (busy_q) begin
      rad_q  <= {rad_q[RW-3:0], 2'b00};
      root_q <= {root_q[QW-2:0], ge};
      rem_q  <= ge ? MW'(rem_sh - trial) : MW'(rem_sh);
    end
  end

endmodule
`default_nettype wire

// ===== rtl/rmsidg_back.sv =====
`default_nettype none
module rmsidg_back #(
  parameter int unsigned SAMPLE_BITS   = rmsidg_pkg::SAMPLE_BITS,
  parameter int unsigned HISTORY_DEPTH = rmsidg_pkg::HISTORY_DEPTH,
  parameter int unsigned CHANNELS      = rmsidg_pkg::CHANNELS
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic [rmsidg_pkg::WINDOW_W-1:0]   window_i,
  input  logic [rmsidg_pkg::BLOCK_W-1:0]    block_i,
  input  logic                              pop_valid_i,
  output logic                              pop_ready_o,
  input  logic [SAMPLE_BITS+1:0]            pop_data_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [SAMPLE_BITS-1:0]            out_sample_o,
  output logic                              out_channel_o
);

  localparam int unsigned SB        = SAMPLE_BITS;
  localparam int unsigned HD        = HISTORY_DEPTH;
  localparam int unsigned PW        = $clog2(HD);
  localparam int unsigned NW        = $clog2(HD + 1);
  localparam int unsigned CIW       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned MEM_DEPTH = CHANNELS * HD;
  localparam int unsigned AW        = $clog2(MEM_DEPTH);
  localparam int unsigned DN        = (SB > 24) ? SB - 24 : 0;
  localparam int unsigned UP        = (SB < 24) ? 24 - SB : 0;
  localparam int unsigned BW        = rmsidg_pkg::BLOCK_W;
  localparam int unsigned LW        = rmsidg_pkg::LEVEL_W;
  localparam int unsigned PBW       = rmsidg_pkg::BPOS_W;
  localparam int unsigned GW        = rmsidg_pkg::GAIN_W;
  localparam int unsigned PRW       = LW + BW;
  localparam int unsigned MAG_W     = SB + 23;
  localparam int unsigned DW        = rmsidg_pkg::DIV_W;
  localparam int unsigned VW        = rmsidg_pkg::DIVISOR_W;
  localparam int unsigned RW        = rmsidg_pkg::SQRT_W;

  typedef enum logic [12:0] {
    S_IDLE  = 13'b0000000000001,
    S_LOAD  = 13'b0000000000010,
    S_WALK  = 13'b0000000000100,
    S_MDIV  = 13'b0000000001000,
    S_MSQRT = 13'b0000000010000,
    S_WRITE = 13'b0000000100000,
    S_IMUL  = 13'b0000001000000,
    S_IDIV  = 13'b0000010000000,
    S_SSQRT = 13'b0000100000000,
    S_GDIV  = 13'b0001000000000,
    S_GMUL  = 13'b0010000000000,
    S_GADD  = 13'b0100000000000,
    S_OUT   = 13'b1000000000000
  } state_e;

  state_e state_q, state_d;

  logic [SB-1:0]  hist_mem_q [MEM_DEPTH];

  logic [PW-1:0]  wpos_q [CHANNELS];
  logic [NW-1:0]  fill_q [CHANNELS];
  logic [PBW-1:0] bpos_q [CHANNELS];
  logic [LW-1:0]  old_q  [CHANNELS];
  logic [LW-1:0]  new_q  [CHANNELS];

  logic signed [SB-1:0] x_q;
  logic                 ch_q, pass_q;
  logic [PBW-1:0]       p_q;
  logic [NW-1:0]        m_q, n_q, iss_q;
  logic [PW-1:0]        ridx_q;
  logic [63:0]          sum_q;
  logic signed [SB-1:0] rdata_q;
  logic                 rd_v_q, sq_v_q;
  logic [46:0]          sq_q;
  logic [PRW-1:0]       prod_a_q, prod_b_q;
  logic signed [GW-1:0] gain_q;
  logic [SB+21:0]       p_hi_q;
  logic [SB+15:0]       p_lo_q;
  logic                 neg_q;
  logic [MAG_W-1:0]     mag_q;
  logic                 out_valid_q, out_ch_q;
  logic [SB-1:0]        out_sample_q;

  rmsidg_pkg::item_ctl_t pop_ctl;
  logic [CIW-1:0]        ci;
  logic [31:0]           win32, blk32;
  logic [BW-1:0]         b_eff;
  logic [NW-1:0]         n_eff, m_eff;
  logic [PBW-1:0]        p_eff;
  logic [PW-1:0]         ridx_dec;
  logic                  walk_issue, walk_done;
  logic [AW-1:0]         raddr, waddr;
  logic signed [23:0]    q24;
  logic signed [47:0]    sq48;
  logic                  div_start, div_done;
  logic [DW-1:0]         div_dividend, div_quo;
  logic [VW-1:0]         div_divisor;
  logic                  sqrt_start, sqrt_done;
  logic [RW-1:0]         sqrt_rad;
  logic [RW/2-1:0]       sqrt_root;
  logic [GW-1:0]         ag;
  logic [SB-1:0]         ax;
  logic [SB-1:0]         y, s_min, s_max;
  logic [MAG_W-1:0]      lim;
  logic                  out_load;

  rmsidg_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  rmsidg_isqrt u_isqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (sqrt_start),
    .radicand_i (sqrt_rad),
    .done_o     (sqrt_done),
    .root_o     (sqrt_root)
  );

  assign pop_ctl       = rmsidg_pkg::item_ctl_t'(pop_data_i[SB+1:SB]);
  assign pop_ready_o   = (state_q == S_IDLE);
  assign out_valid_o   = out_valid_q;
  assign out_sample_o  = out_sample_q;
  assign out_channel_o = out_ch_q;
  assign ci            = CIW'(ch_q);

  always_comb begin
    win32 = 32'(window_i);
    blk32 = 32'(block_i);
    if (win32 == 32'd0) begin
      n_eff = NW'(1);
    end else if (win32 > 32'(HD)) begin
      n_eff = NW'(HD);
    end else begin
      n_eff = NW'(win32);
    end
    if (blk32 == 32'd0) begin
      b_eff = BW'(1);
    end else if (blk32 > 32'(rmsidg_pkg::MAX_BLOCK)) begin
      b_eff = BW'(rmsidg_pkg::MAX_BLOCK);
    end else begin
      b_eff = BW'(blk32);
    end
    m_eff = (n_eff < fill_q[ci]) ? n_eff : fill_q[ci];
    p_eff = (BW'(bpos_q[ci]) >= b_eff) ? '0 : bpos_q[ci];
  end

  assign ridx_dec   = (ridx_q == '0) ? PW'(HD - 1) : ridx_q - 1'b1;
  assign walk_issue = (state_q == S_WALK) && (iss_q != m_q);
  assign walk_done  = (state_q == S_WALK) && (iss_q == m_q) && !rd_v_q && !sq_v_q;
  assign raddr      = AW'(32'(ci) * 32'(HD) + 32'(ridx_dec));
  assign waddr      = AW'(32'(ci) * 32'(HD) + 32'(wpos_q[ci]));

  always_comb begin
    q24  = 24'(rdata_q >>> DN) <<< UP;
    sq48 = q24 * q24;
  end

  always_comb begin
    div_start    = 1'b0;
    div_dividend = '0;
    div_divisor  = '0;
    sqrt_start   = 1'b0;
    sqrt_rad     = '0;
    case (state_q)
      S_WALK: begin
        div_start    = walk_done;
        div_dividend = sum_q;
        div_divisor  = VW'(n_q);
      end
      S_MDIV: begin
        sqrt_start = div_done;
        sqrt_rad   = div_quo;
      end
      S_IMUL: begin
        div_start    = 1'b1;
        div_dividend = DW'(prod_a_q) + DW'(prod_b_q);
        div_divisor  = VW'(b_eff);
      end
      S_IDIV: begin
        sqrt_start = div_done;
        sqrt_rad   = RW'(div_quo[LW-1:0]) << 25;
      end
      S_SSQRT: begin
        div_start    = sqrt_done;
        div_dividend = DW'(1) << 40;
        div_divisor  = VW'(sqrt_root) + VW'(rmsidg_pkg::EPS_Q24);
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  always_comb begin
    ag    = gain_q[GW-1] ? GW'(-gain_q) : GW'(gain_q);
    ax    = x_q[SB-1] ? SB'(-x_q) : SB'(x_q);
    lim   = MAG_W'(1) << (SB - 1);
    s_min = SB'(1) << (SB - 1);
    s_max = ~s_min;
    if (pass_q) begin
      y = x_q;
    end else if (neg_q) begin
      y = (mag_q > lim) ? s_min : SB'(0) - mag_q[SB-1:0];
    end else begin
      y = (mag_q > lim - 1'b1) ? s_max : mag_q[SB-1:0];
    end
  end

  assign out_load = (state_q == S_OUT) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (pop_valid_i) begin
          state_d = pop_ctl.pass ? S_OUT : S_LOAD;
        end
      end
      S_LOAD:  state_d = (p_eff == '0) ? S_WALK : S_WRITE;
      S_WALK:  state_d = walk_done ? S_MDIV : S_WALK;
      S_MDIV:  state_d = div_done ? S_MSQRT : S_MDIV;
      S_MSQRT: state_d = sqrt_done ? S_WRITE : S_MSQRT;
      S_WRITE: state_d = S_IMUL;
      S_IMUL:  state_d = S_IDIV;
      S_IDIV:  state_d = div_done ? S_SSQRT : S_IDIV;
      S_SSQRT: state_d = sqrt_done ? S_GDIV : S_SSQRT;
      S_GDIV:  state_d = div_done ? S_GMUL : S_GDIV;
      S_GMUL:  state_d = S_GADD;
      S_GADD:  state_d = S_OUT;
      S_OUT:   state_d = out_load ? S_IDLE : S_OUT;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      rd_v_q      <= 1'b0;
      sq_v_q      <= 1'b0;
      out_valid_q <= 1'b0;
      for (int c = 0; c < int'(CHANNELS); c++) begin
        wpos_q[c] <= '0;
        fill_q[c] <= '0;
        bpos_q[c] <= '0;
        old_q[c]  <= '0;
        new_q[c]  <= '0;
      end
    end else begin
      state_q <= state_d;
      rd_v_q  <= walk_issue;
      sq_v_q  <= rd_v_q;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if ((state_q == S_LOAD) && (p_eff == '0)) begin
        old_q[ci] <= new_q[ci];
      end
      if ((state_q == S_MSQRT) && sqrt_done) begin
        new_q[ci] <= sqrt_root[LW-1:0];
      end
      if (state_q == S_WRITE) begin
        wpos_q[ci] <= (wpos_q[ci] == PW'(HD - 1)) ? '0 : wpos_q[ci] + 1'b1;
        fill_q[ci] <= (fill_q[ci] == NW'(HD)) ? fill_q[ci] : fill_q[ci] + 1'b1;
        bpos_q[ci] <= (BW'(p_q) + 1'b1 >= b_eff) ? '0 : p_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (walk_issue) begin
      rdata_q <= hist_mem_q[raddr];
    end
    if (state_q == S_WRITE) begin
      hist_mem_q[waddr] <= x_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_valid_i && pop_ready_o) begin
      x_q    <= pop_data_i[SB-1:0];
      ch_q   <= pop_ctl.channel;
      pass_q <= pop_ctl.pass;
    end
    if (state_q == S_LOAD) begin
      p_q    <= p_eff;
      m_q    <= m_eff;
      n_q    <= n_eff;
      iss_q  <= '0;
      ridx_q <= wpos_q[ci];
      sum_q  <= '0;
    end else begin
      if (walk_issue) begin
        iss_q  <= iss_q + 1'b1;
        ridx_q <= ridx_dec;
      end
      if (sq_v_q) begin
        sum_q <= sum_q + 64'(sq_q);
      end
    end
    if (rd_v_q) begin
      sq_q <= sq48[46:0];
    end
    if (state_q == S_WRITE) begin
      prod_a_q <= PRW'(old_q[ci]) * PRW'(b_eff - BW'(p_q));
      prod_b_q <= PRW'(new_q[ci]) * PRW'(p_q);
    end
    if ((state_q == S_GDIV) && div_done) begin
      gain_q <= $signed(div_quo[GW-1:0]) - $signed(GW'(rmsidg_pkg::GAIN_ONE));
    end
    if (state_q == S_GMUL) begin
      p_hi_q <= (SB + 22)'(ax) * (SB + 22)'(ag[GW-1:16]);
      p_lo_q <= (SB + 16)'(ax) * (SB + 16)'(ag[15:0]);
      neg_q  <= x_q[SB-1] ^ gain_q[GW-1];
    end
    if (state_q == S_GADD) begin
      mag_q <= MAG_W'(p_hi_q) + MAG_W'(p_lo_q >> 16);
    end
    if (out_load) begin
      out_sample_q <= y;
      out_ch_q     <= ch_q;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/rmsidg_checker.sv =====
`default_nettype none
`include "rms_inverse_dynamics_gain_core_assert.svh"
module rmsidg_checker #(
  parameter int unsigned SAMPLE_BITS = rmsidg_pkg::SAMPLE_BITS,
  localparam int unsigned TDW        = (SAMPLE_BITS + 7) / 8 * 8
) (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           s_axis_tvalid,
  input logic           s_axis_tready,
  input logic           m_axis_tvalid,
  input logic           m_axis_tready,
  input logic [TDW-1:0] m_axis_tdata,
  input logic [0:0]     m_axis_tuser
);

  logic [2:0] pend_q;
  logic       in_acc, out_acc;

  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign out_acc = m_axis_tvalid && m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else if (in_acc && !out_acc) begin
      pend_q <= pend_q + 1'b1;
    end else if (out_acc && !in_acc) begin
      pend_q <= pend_q - 1'b1;
    end
  end

  `RIDG_ASSERT(a_out_hold, (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)), "output word changed while stalled")
  `RIDG_ASSERT_RST(a_rst_quiet, !rst_ni |-> !m_axis_tvalid, "output valid during reset")
  `RIDG_ASSERT(a_no_spurious, m_axis_tvalid |-> (pend_q != 3'd0), "output word without input word")
  `RIDG_ASSERT(a_pend_bound, pend_q <= 3'd5, "more words in flight than storage holds")

endmodule

bind rms_inverse_dynamics_gain_core rmsidg_checker #(
  .SAMPLE_BITS (SAMPLE_BITS)
) u_rmsidg_checker (.*);
`default_nettype wire

// ===== tb/rms_inverse_dynamics_gain_core_checker.sv =====
module rms_inverse_dynamics_gain_core_checker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [rmsidg_pkg::CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [rmsidg_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                              s_axis_tvalid,
  input  logic                              s_axis_tready,
  input  logic [23:0]                       s_axis_tdata,
  input  logic [0:0]                        s_axis_tuser,
  input  logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  input  logic [23:0]                       m_axis_tdata,
  input  logic [0:0]                        m_axis_tuser,
  output int                                pending_o,
  output int                                fails_o,
  output int                                words_o,
  output int                                blocks_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [23:0] sample;
    logic        chan;
  } gain_word_t;

  gain_word_t gain_words_due[$];

  bit signed [23:0] history [2][rmsidg_pkg::HISTORY_DEPTH];
  int unsigned held [2];
  int unsigned wr_pos [2];
  int unsigned blk_pos [2];
  longint unsigned lvl_old [2];
  longint unsigned lvl_new [2];
  logic [rmsidg_pkg::WINDOW_W-1:0] window_reg = rmsidg_pkg::WINDOW_RESET;
  logic [rmsidg_pkg::BLOCK_W-1:0]  block_reg  = rmsidg_pkg::BLOCK_RESET;

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint unsigned window_rms(int ch);
    longint unsigned n, m, sum, q;
    int unsigned idx;
    n = (window_reg == 0) ? 1 :
        ((window_reg > rmsidg_pkg::HISTORY_DEPTH) ? rmsidg_pkg::HISTORY_DEPTH : window_reg);
    m = (n < held[ch]) ? n : held[ch];
    idx = wr_pos[ch];
    sum = 0;
    for (longint unsigned i = 0; i < m; i++) begin
      idx = (idx == 0) ? rmsidg_pkg::HISTORY_DEPTH - 1 : idx - 1;
      q = longint'(history[ch][idx]) * longint'(history[ch][idx]);
      sum += q;
    end
    return int_sqrt(sum / n);
  endfunction

  function automatic gain_word_t predict_gain(logic [23:0] din, logic chan);
    gain_word_t w;
    longint x, gain, y;
    longint unsigned b, p, lvl, s, ax, ag, mag, lim;
    bit neg;
    int ch;
    ch = chan;
    x = longint'($signed(din));
    b = (block_reg == 0) ? 1 :
        ((block_reg > rmsidg_pkg::MAX_BLOCK) ? rmsidg_pkg::MAX_BLOCK : block_reg);
    p = blk_pos[ch];
    if (p >= b) p = 0;
    if (p == 0) begin
      lvl_old[ch] = lvl_new[ch];
      lvl_new[ch] = window_rms(ch);
      blocks_o++;
    end
    history[ch][wr_pos[ch]] = din;
    wr_pos[ch] = (wr_pos[ch] + 1 >= rmsidg_pkg::HISTORY_DEPTH) ? 0 : wr_pos[ch] + 1;
    if (held[ch] < rmsidg_pkg::HISTORY_DEPTH) held[ch]++;
    blk_pos[ch] = (p + 1 >= b) ? 0 : p + 1;
    lvl = (lvl_old[ch] * (b - p) + lvl_new[ch] * p) / b;
    s = int_sqrt(lvl << 25);
    gain = longint'((64'd1 << 40) / (s + rmsidg_pkg::EPS_Q24)) - rmsidg_pkg::GAIN_ONE;
    neg = (x < 0) != (gain < 0);
    ax = (x < 0) ? -x : x;
    ag = (gain < 0) ? -gain : gain;
    mag = ax * (ag >> 16) + ((ax * (ag & 64'hFFFF)) >> 16);
    lim = 64'd1 << 23;
    if (neg) y = (mag > lim) ? -longint'(lim) : -longint'(mag);
    else     y = (mag > lim - 1) ? longint'(lim - 1) : longint'(mag);
    w.sample = y[23:0];
    w.chan = chan;
    return w;
  endfunction

  initial begin
    fails_o = 0;
    words_o = 0;
    blocks_o = 0;
  end

  assign pending_o = gain_words_due.size();

  always @(posedge clk_i) begin
    gain_word_t got, want;
    if (rst_ni) begin
      if (cfg_we_i) begin
        if (cfg_addr_i == rmsidg_pkg::REG_WINDOW)
          window_reg = cfg_wdata_i[rmsidg_pkg::WINDOW_W-1:0];
        else if (cfg_addr_i == rmsidg_pkg::REG_BLOCK)
          block_reg = cfg_wdata_i[rmsidg_pkg::BLOCK_W-1:0];
      end
      if (s_axis_tvalid && s_axis_tready)
        gain_words_due.push_back(predict_gain(s_axis_tdata, s_axis_tuser[0]));
      if (m_axis_tvalid && m_axis_tready) begin
        got.sample = m_axis_tdata;
        got.chan = m_axis_tuser[0];
        words_o++;
        if (gain_words_due.size() == 0) begin
          fails_o++;
          $display("%t: unexpected word sample=%h ch=%0d", $realtime, got.sample, got.chan);
        end else begin
          want = gain_words_due.pop_front();
          if (got !== want) begin
            fails_o++;
            $display("%t: mismatch expected sample=%h ch=%0d actual sample=%h ch=%0d",
                     $realtime, want.sample, want.chan, got.sample, got.chan);
          end
        end
      end
    end
  end
endmodule

// ===== tb/rms_inverse_dynamics_gain_core_tb.sv =====
module rms_inverse_dynamics_gain_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 150000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [rmsidg_pkg::CFG_ADDR_W-1:0] cfg_addr_i = rmsidg_pkg::REG_WINDOW;
  logic [rmsidg_pkg::CFG_DATA_W-1:0] cfg_wdata_i = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [23:0] s_axis_tdata = '0;  // sample_in
  logic [0:0] s_axis_tuser = '0;   // channel
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;       // sample_out
  logic [0:0] m_axis_tuser;        // channel_out

  int pending, fails, words, blocks;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int quiet_cycles = 0;
  int sent = 0;

  always #5 clk_i = ~clk_i;

  rms_inverse_dynamics_gain_core DUT (.*);

  rms_inverse_dynamics_gain_core_checker u_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_addr_i, .cfg_wdata_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .pending_o(pending), .fails_o(fails), .words_o(words), .blocks_o(blocks)
  );

  always @(posedge clk_i)
    m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("%t: no progress, %0d words outstanding", $realtime, pending);
      $display("rms_inverse_dynamics_gain_core regression: fail");
      $finish;
    end
  end

  task automatic send_word(logic [23:0] smp, logic ch);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= smp;
    s_axis_tuser <= ch;
    do @(posedge clk_i); while (!s_axis_tready);
    sent++;
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
  endtask

  task automatic set_regs(int unsigned win, int unsigned blk);
    drain();
    cfg_we_i <= 1'b1;
    cfg_addr_i <= rmsidg_pkg::REG_WINDOW;
    cfg_wdata_i <= win;
    @(posedge clk_i);
    cfg_addr_i <= rmsidg_pkg::REG_BLOCK;
    cfg_wdata_i <= blk;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [23:0] pick_sample();
    logic [23:0] r;
    r = $urandom;
    case ($urandom_range(5))
      0: return r;
      1: return $urandom_range(1) ? 24'h7FFFFF : 24'h800000;
      2: return 24'($signed(r) >>> $urandom_range(23));
      3: return 24'($signed(r[8:0]));
      4: return 24'($signed(r) >>> 2);
      default: return $urandom_range(3) == 0 ? 24'h0 : r;
    endcase
  endfunction

  task automatic run_random(int n, int mode);
    case (mode)
      0: begin tx_idle_pct = 0;  rx_idle_pct = 0;  end
      1: begin tx_idle_pct = 71; rx_idle_pct = 0;  end
      2: begin tx_idle_pct = 0;  rx_idle_pct = 71; end
      default: begin tx_idle_pct = 38; rx_idle_pct = 38; end
    endcase
    repeat (n) send_word(pick_sample(), $urandom_range(1));
  endtask

  initial begin
    logic [23:0] edge_vals [8] = '{24'h7FFFFF, 24'h800000, 24'h000000, 24'h000001,
                                   24'hFFFFFF, 24'h400000, 24'hC00000, 24'h000100};
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (edge_vals[i]) send_word(edge_vals[i], i[0]);
    set_regs(0, 0);
    foreach (edge_vals[i]) send_word(edge_vals[i], 1'b0);
    set_regs(16'hFFFF, 13'h1FFF);
    repeat (6) send_word(pick_sample(), $urandom_range(1));
    set_regs(3, 5);
    repeat (6) send_word(24'h7FFFFF, 1'b1);

    for (int ph = 0; ph < 8; ph++) begin
      set_regs($urandom_range(1, 48), $urandom_range(1, 12));
      run_random(180, ph % 4);
    end
    set_regs(32768, 4096);
    run_random(60, 3);
    set_regs(1, 1);
    run_random(80, 2);
    set_regs($urandom_range(200, 2000), $urandom_range(20, 300));
    run_random(100, 1);

    drain();
    $display("%0d samples sent across both channels, %0d checked, %0d level updates,",
             sent, words, blocks);
    $display("window and block sizes swept from the clamp limits to small random values");
    if (fails == 0) begin
      $display("rms_inverse_dynamics_gain_core regression: pass");
    end else begin
      $display("rms_inverse_dynamics_gain_core regression: fail");
    end
    $finish;
  end
endmodule
